// ===== src/sgd_factorization_negative_sampling_core_defines.svh =====
// assertion macros for the sgd factorization core
`ifndef SGD_FACTORIZATION_NEGATIVE_SAMPLING_CORE_DEFINES_SVH
`define SGD_FACTORIZATION_NEGATIVE_SAMPLING_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// consequent holds in the same cycle as the antecedent
`define SGDNS_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sgdns assertion failed");
// consequent holds in the cycle after the antecedent
`define SGDNS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sgdns assertion failed");
`else
`define SGDNS_ASSERT_HOLDS(label, clk, rst, ante, cons)
`define SGDNS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/sgdns_pkg.sv =====
// shared types, constants and helper functions of the sgd factorization core
package sgdns_pkg;

   localparam int MAX_ROWS    = 4096;
   localparam int MAX_COLUMNS = 4096;
   localparam int MAX_DIM     = 128;

   localparam int ROW_W   = $clog2(MAX_ROWS);
   localparam int COL_W   = $clog2(MAX_COLUMNS);
   localparam int DIM_W   = $clog2(MAX_DIM);
   localparam int COUNT_W = 13;
   localparam int LEN_W   = $clog2(MAX_DIM + 1);
   localparam int WADDR_W = ROW_W + DIM_W;
   localparam int CADDR_W = COL_W + DIM_W;
   localparam int WDEPTH  = MAX_ROWS * MAX_DIM;
   localparam int CDEPTH  = MAX_COLUMNS * MAX_DIM;

   localparam int DIV_W   = 48;
   localparam int DVS_W   = 13;
   localparam int DCNT_W  = $clog2(DIV_W + 1);

   localparam int REQ_DATA_W  = 64;
   localparam int REQ_USER_W  = 3;
   localparam int RSP_DATA_W  = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [34:0] LCG_MUL    = 35'h5DEECE66D;
   localparam logic [15:0] LCG_MUL16  = 16'hE66D;
   localparam logic [15:0] LCG_ADD16  = 16'd11;
   localparam logic [15:0] RATE_RESET = 16'd13107;
   // ceil(2^22/5), exact quotient by 5 for the 18-bit rate*4 after a shift by 22
   localparam logic [32:0] RATE_DIV5_MUL = 33'd838861;

   typedef enum logic [1:0] {
      ACT_TRAIN = 2'd0,
      ACT_PASS  = 2'd1,
      ACT_INIT  = 2'd2,
      ACT_READ  = 2'd3
   } action_type;

   localparam logic [CSR_INDEX_W-1:0] REG_LEARNING_RATE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PMI_NEGATIVES = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ESA_NEGATIVES = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PMI_COLUMNS   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_ESA_COLUMNS   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_WORD_ROWS     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_VECTOR_LENGTH = 3'd6;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DIV_W-1:0] quotient;
      logic [DVS_W-1:0] remainder;
   } div_rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v,
                                                      input logic [COUNT_W-1:0] bound);
      logic [COUNT_W-1:0] r;
      if (v == '0) begin
         r = COUNT_W'(1);
      end else if (v > bound) begin
         r = bound;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [LEN_W-1:0] clamp_len(input logic [7:0] v);
      logic [LEN_W-1:0] r;
      if (v == 8'd0) begin
         r = LEN_W'(1);
      end else if (v > 8'(MAX_DIM)) begin
         r = LEN_W'(MAX_DIM);
      end else begin
         r = LEN_W'(v);
      end
      return r;
   endfunction

endpackage

// ===== src/sgdns_mul.sv =====
// shared signed multiplier with a registered product
module sgdns_mul (
   input  logic                clock,
   input  logic signed [32:0]  op_a,
   input  logic signed [32:0]  op_b,
   output logic signed [65:0]  prod
);
   import sgdns_pkg::*;

   logic signed [65:0] prod_ff;
   logic signed [65:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ===== src/sgdns_div.sv =====
// shared restoring divider, one quotient bit per cycle
module sgdns_div (
   input  logic                      clock,
   input  logic                      reset,
   input  sgdns_pkg::div_req_type    req,
   output sgdns_pkg::div_rsp_type    rsp
);
   import sgdns_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]  dvd_ff, dvd_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DVS_W:0]    shifted;
   logic [DVS_W:0]    diff;
   logic              fits;

   assign shifted = {rem_ff, dvd_ff[DIV_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign fits    = (shifted >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = DCNT_W'(DIV_W);
         dvd_in  = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         // quotient bits shift in where dividend bits leave
         dvd_in = {dvd_ff[DIV_W-2:0], fits};
         rem_in = fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
         cnt_in = cnt_ff - DCNT_W'(1);
         if (cnt_ff == DCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.busy      = busy_ff;
   assign rsp.done      = done_ff;
   assign rsp.quotient  = dvd_ff;
   assign rsp.remainder = rem_ff;

endmodule

// ===== src/sgd_factorization_negative_sampling_core.sv =====
// top level: sequencer, tables and configuration of the sgd factorization core
// The core trains a word table against a PPMI and an ESA context table with negative
// sampling, in signed Q16.16 with saturation, using one shared 33x33 multiplier and one
// shared 48-step divider under a sequencer; it takes one item at a time. A read issues
// the address and then returns the registered word; an end of pass scales the rate by
// 4/5 (reciprocal multiply). An init first clears both context tables, one entry a cycle
// (MAX_COLUMNS*MAX_DIM = 524288 entries), then fills rows*len word elements, one
// divider run each. The time of a train item with len elements and n negatives is set
// by the single multiplier and the one read port of each table.
`include "sgd_factorization_negative_sampling_core_defines.svh"
module sgd_factorization_negative_sampling_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // row[11:0], column[23:12], element[30:24], target[62:31], zero pad[63]
   input  logic [sgdns_pkg::REQ_DATA_W-1:0]    req_tdata,
   // action[1:0], matrix_sel[2]
   input  logic [sgdns_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // read_data[31:0]
   output logic [sgdns_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sgdns_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [sgdns_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import sgdns_pkg::*;

   typedef enum logic [20:0] {
      S_IDLE        = 21'h000001,
      S_DONE        = 21'h000002,
      S_RD_ISSUE    = 21'h000004,
      S_RD_DATA     = 21'h000008,
      S_PASS_MUL    = 21'h000010,
      S_INIT_CLR    = 21'h000020,
      S_INIT_GEN    = 21'h000040,
      S_INIT_DIV    = 21'h000080,
      S_T_DOT_ISSUE = 21'h000100,
      S_T_DOT_MUL   = 21'h000200,
      S_T_DOT_ACC   = 21'h000400,
      S_T_ERR       = 21'h000800,
      S_T_STEP      = 21'h001000,
      S_T_UPD_ISSUE = 21'h002000,
      S_T_UPD_M1    = 21'h004000,
      S_T_UPD_M2    = 21'h008000,
      S_T_UPD_WR    = 21'h010000,
      S_T_NEXT      = 21'h020000,
      S_T_SEED      = 21'h040000,
      S_T_ROW_ISSUE = 21'h080000,
      S_T_ROW_WR    = 21'h100000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [15:0]        lrate_ff, lrate_in;
   logic [3:0]         pneg_ff, pneg_in;
   logic [3:0]         eneg_ff, eneg_in;
   logic [COUNT_W-1:0] pcols_ff, pcols_in;
   logic [COUNT_W-1:0] ecols_ff, ecols_in;
   logic [COUNT_W-1:0] wrows_ff, wrows_in;
   logic [7:0]         vlen_ff, vlen_in;

   // persistent state
   logic [15:0]        rate_ff, rate_in;
   logic [COL_W-1:0]   seed_ff, seed_in;
   logic [MAX_DIM-1:0] rcv_ff, rcv_in;

   // item and loop registers
   logic               sel_ff, sel_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [DIM_W-1:0]   elem_ff, elem_in;
   logic signed [31:0] tgt_ff, tgt_in;
   logic [3:0]         negs_ff, negs_in;
   logic [3:0]         samp_ff, samp_in;
   logic [DIM_W-1:0]   j_ff, j_in;
   logic [ROW_W-1:0]   r_ff, r_in;
   logic [CADDR_W-1:0] clr_ff, clr_in;
   logic signed [55:0] acc_ff, acc_in;
   logic signed [31:0] step_ff, step_in;
   logic signed [31:0] w_ff, w_in;
   logic signed [31:0] old_ff, old_in;
   logic signed [31:0] rc_ff, rc_in;
   logic [15:0]        lcg_ff, lcg_in;
   logic               neg_ff, neg_in;
   logic [31:0]        res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_data_ff, rsp_data_in;

   // tables
   logic [31:0] word_mem [0:WDEPTH-1];
   logic [31:0] pmi_mem  [0:CDEPTH-1];
   logic [31:0] esa_mem  [0:CDEPTH-1];
   logic [31:0] rc_mem   [0:MAX_DIM-1];
   logic signed [31:0] word_rd_ff, pmi_rd_ff, esa_rd_ff, rc_rd_ff;
   logic               rcv_rd_ff;

   logic               word_we;
   logic [WADDR_W-1:0] word_waddr, word_raddr;
   logic [31:0]        word_wdata;
   logic               pmi_we, esa_we;
   logic [CADDR_W-1:0] ctx_waddr, ctx_raddr;
   logic [31:0]        ctx_wdata;
   logic               rc_we;
   logic [31:0]        rc_wdata;

   // shared units
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_prod;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   // datapath helpers
   logic               req_fire;
   logic               csr_fire;
   action_type         req_action;
   logic [LEN_W-1:0]   len;
   logic [COUNT_W-1:0] rows;
   logic [COUNT_W-1:0] cmod;
   logic               j_last;
   logic signed [31:0] ctx_rd;
   logic signed [49:0] prod_sh;
   logic signed [31:0] prod_sat;
   logic signed [31:0] f_sat, g_sat;
   logic signed [31:0] rc_sum, ctx_sum, row_sum, rc_eff;
   logic [31:0]        lcg_prod;
   logic [15:0]        lcg_next;
   logic [16:0]        mag_full;
   logic [31:0]        init_val;

   sgdns_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_prod)
   );

   sgdns_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid && csr_ready;
   assign req_action = action_type'(req_tuser[1:0]);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign len    = clamp_len(vlen_ff);
   assign rows   = clamp_count(wrows_ff, COUNT_W'(MAX_ROWS));
   assign cmod   = clamp_count(sel_ff ? ecols_ff : pcols_ff, COUNT_W'(MAX_COLUMNS));
   assign j_last = ({1'b0, j_ff} == (len - LEN_W'(1)));
   assign ctx_rd = sel_ff ? esa_rd_ff : pmi_rd_ff;

   // floor shift by 16 of the last product, then saturate
   assign prod_sh  = mul_prod[65:16];
   assign prod_sat = sat32({{14{prod_sh[49]}}, prod_sh});
   assign f_sat    = sat32({{8{acc_ff[55]}}, acc_ff});
   assign g_sat    = sat32({{32{tgt_ff[31]}}, tgt_ff} - {{32{f_sat[31]}}, f_sat});
   assign rc_sum   = sat32({{32{rc_ff[31]}}, rc_ff} + {{32{prod_sat[31]}}, prod_sat});
   assign ctx_sum  = sat32({{32{old_ff[31]}}, old_ff} + {{32{prod_sat[31]}}, prod_sat});
   assign rc_eff   = rcv_rd_ff ? rc_rd_ff : 32'sd0;
   assign row_sum  = sat32({{32{word_rd_ff[31]}}, word_rd_ff} + {{32{rc_eff[31]}}, rc_eff});

   // only the low 16 bits of the init generator matter, and they evolve on their own
   assign lcg_prod = 32'(lcg_ff) * 32'(LCG_MUL16);
   assign lcg_next = lcg_prod[15:0] + LCG_ADD16;
   assign mag_full = lcg_next[15] ? {2'b00, lcg_next[14:0]}
                                  : (17'd32768 - {1'b0, lcg_next});
   assign init_val = neg_ff ? (32'd0 - {15'd0, div_rsp.quotient[16:0]})
                            : {15'd0, div_rsp.quotient[16:0]};

   always_comb begin
      state_in     = state_ff;
      lrate_in     = lrate_ff;
      pneg_in      = pneg_ff;
      eneg_in      = eneg_ff;
      pcols_in     = pcols_ff;
      ecols_in     = ecols_ff;
      wrows_in     = wrows_ff;
      vlen_in      = vlen_ff;
      rate_in      = rate_ff;
      seed_in      = seed_ff;
      rcv_in       = rcv_ff;
      sel_in       = sel_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      elem_in      = elem_ff;
      tgt_in       = tgt_ff;
      negs_in      = negs_ff;
      samp_in      = samp_ff;
      j_in         = j_ff;
      r_in         = r_ff;
      clr_in       = clr_ff;
      acc_in       = acc_ff;
      step_in      = step_ff;
      w_in         = w_ff;
      old_in       = old_ff;
      rc_in        = rc_ff;
      lcg_in       = lcg_ff;
      neg_in       = neg_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      word_we    = 1'b0;
      word_waddr = {row_ff, j_ff};
      word_wdata = row_sum;
      word_raddr = {row_ff, j_ff};
      pmi_we     = 1'b0;
      esa_we     = 1'b0;
      ctx_waddr  = {col_ff, j_ff};
      ctx_wdata  = ctx_sum;
      ctx_raddr  = {col_ff, j_ff};
      rc_we      = 1'b0;
      rc_wdata   = rc_sum;
      mul_a      = '0;
      mul_b      = '0;
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = DVS_W'(1);

      if (csr_fire) begin
         unique case (csr_index)
            REG_LEARNING_RATE: lrate_in = csr_wdata;
            REG_PMI_NEGATIVES: pneg_in  = csr_wdata[3:0];
            REG_ESA_NEGATIVES: eneg_in  = csr_wdata[3:0];
            REG_PMI_COLUMNS:   pcols_in = csr_wdata[COUNT_W-1:0];
            REG_ESA_COLUMNS:   ecols_in = csr_wdata[COUNT_W-1:0];
            REG_WORD_ROWS:     wrows_in = csr_wdata[COUNT_W-1:0];
            REG_VECTOR_LENGTH: vlen_in  = csr_wdata[7:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               row_in  = req_tdata[11:0];
               col_in  = req_tdata[23:12];
               elem_in = req_tdata[30:24];
               tgt_in  = req_tdata[62:31];
               sel_in  = req_tuser[2];
               negs_in = req_tuser[2] ? eneg_ff : pneg_ff;
               samp_in = '0;
               j_in    = '0;
               r_in    = '0;
               clr_in  = '0;
               acc_in  = '0;
               unique case (req_action)
                  ACT_TRAIN: begin
                     rcv_in   = '0;
                     state_in = S_T_DOT_ISSUE;
                  end
                  ACT_PASS: begin
                     // rate*4/5 by reciprocal multiplication
                     mul_a    = {15'd0, rate_ff, 2'b00};
                     mul_b    = RATE_DIV5_MUL;
                     state_in = S_PASS_MUL;
                  end
                  ACT_INIT: begin
                     lcg_in   = 16'd1;
                     state_in = S_INIT_CLR;
                  end
                  ACT_READ: begin
                     state_in = S_RD_ISSUE;
                  end
                  default: ;
               endcase
            end
         end
         S_RD_ISSUE: begin
            word_raddr = {row_ff, elem_ff};
            state_in   = S_RD_DATA;
         end
         S_RD_DATA: begin
            res_in   = word_rd_ff;
            state_in = S_DONE;
         end
         S_PASS_MUL: begin
            rate_in  = mul_prod[37:22];
            res_in   = '0;
            state_in = S_DONE;
         end
         S_INIT_CLR: begin
            pmi_we    = 1'b1;
            esa_we    = 1'b1;
            ctx_waddr = clr_ff;
            ctx_wdata = '0;
            clr_in    = clr_ff + CADDR_W'(1);
            if (clr_ff == '1) begin
               state_in = S_INIT_GEN;
            end
         end
         S_INIT_GEN: begin
            lcg_in           = lcg_next;
            neg_in           = ~lcg_next[15];
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(mag_full);
            div_req.divisor  = DVS_W'(len);
            state_in         = S_INIT_DIV;
         end
         S_INIT_DIV: begin
            if (div_rsp.done) begin
               word_we    = 1'b1;
               word_waddr = {r_ff, j_ff};
               word_wdata = init_val;
               if (j_last) begin
                  j_in = '0;
                  if ({1'b0, r_ff} == (rows - COUNT_W'(1))) begin
                     seed_in  = COL_W'(1);
                     rate_in  = lrate_ff;
                     res_in   = '0;
                     state_in = S_DONE;
                  end else begin
                     r_in     = r_ff + ROW_W'(1);
                     state_in = S_INIT_GEN;
                  end
               end else begin
                  j_in     = j_ff + DIM_W'(1);
                  state_in = S_INIT_GEN;
               end
            end
         end
         S_T_DOT_ISSUE: begin
            state_in = S_T_DOT_MUL;
         end
         S_T_DOT_MUL: begin
            mul_a    = {word_rd_ff[31], word_rd_ff};
            mul_b    = {ctx_rd[31], ctx_rd};
            state_in = S_T_DOT_ACC;
         end
         S_T_DOT_ACC: begin
            acc_in = acc_ff + {{6{prod_sh[49]}}, prod_sh};
            if (j_last) begin
               j_in     = '0;
               state_in = S_T_ERR;
            end else begin
               j_in     = j_ff + DIM_W'(1);
               state_in = S_T_DOT_ISSUE;
            end
         end
         S_T_ERR: begin
            mul_a    = {17'd0, rate_ff};
            mul_b    = {g_sat[31], g_sat};
            state_in = S_T_STEP;
         end
         S_T_STEP: begin
            step_in  = prod_sat;
            state_in = S_T_UPD_ISSUE;
         end
         S_T_UPD_ISSUE: begin
            state_in = S_T_UPD_M1;
         end
         S_T_UPD_M1: begin
            mul_a    = {step_ff[31], step_ff};
            mul_b    = {ctx_rd[31], ctx_rd};
            w_in     = word_rd_ff;
            old_in   = ctx_rd;
            rc_in    = rc_eff;
            state_in = S_T_UPD_M2;
         end
         S_T_UPD_M2: begin
            // product of step and the old context element is ready here
            mul_a      = {step_ff[31], step_ff};
            mul_b      = {w_ff[31], w_ff};
            rc_we      = 1'b1;
            rcv_in[j_ff] = 1'b1;
            state_in   = S_T_UPD_WR;
         end
         S_T_UPD_WR: begin
            pmi_we = ~sel_ff;
            esa_we = sel_ff;
            if (j_last) begin
               j_in     = '0;
               state_in = S_T_NEXT;
            end else begin
               j_in     = j_ff + DIM_W'(1);
               state_in = S_T_UPD_ISSUE;
            end
         end
         S_T_NEXT: begin
            if (samp_ff == negs_ff) begin
               state_in = S_T_ROW_ISSUE;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = DIV_W'(seed_ff) * DIV_W'(LCG_MUL) + DIV_W'(11);
               div_req.divisor  = DVS_W'(cmod);
               samp_in          = samp_ff + 4'd1;
               state_in         = S_T_SEED;
            end
         end
         S_T_SEED: begin
            if (div_rsp.done) begin
               seed_in  = div_rsp.remainder[COL_W-1:0];
               col_in   = div_rsp.remainder[COL_W-1:0];
               tgt_in   = '0;
               acc_in   = '0;
               j_in     = '0;
               state_in = S_T_DOT_ISSUE;
            end
         end
         S_T_ROW_ISSUE: begin
            state_in = S_T_ROW_WR;
         end
         S_T_ROW_WR: begin
            word_we = 1'b1;
            if (j_last) begin
               res_in   = '0;
               state_in = S_DONE;
            end else begin
               j_in     = j_ff + DIM_W'(1);
               state_in = S_T_ROW_ISSUE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lrate_ff     <= RATE_RESET;
         pneg_ff      <= 4'd4;
         eneg_ff      <= 4'd4;
         pcols_ff     <= COUNT_W'(MAX_COLUMNS);
         ecols_ff     <= COUNT_W'(MAX_COLUMNS);
         wrows_ff     <= COUNT_W'(MAX_ROWS);
         vlen_ff      <= 8'(MAX_DIM);
         rate_ff      <= RATE_RESET;
         seed_ff      <= COL_W'(1);
         rcv_ff       <= '0;
         negs_ff      <= '0;
         samp_ff      <= '0;
         j_ff         <= '0;
         r_ff         <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lrate_ff     <= lrate_in;
         pneg_ff      <= pneg_in;
         eneg_ff      <= eneg_in;
         pcols_ff     <= pcols_in;
         ecols_ff     <= ecols_in;
         wrows_ff     <= wrows_in;
         vlen_ff      <= vlen_in;
         rate_ff      <= rate_in;
         seed_ff      <= seed_in;
         rcv_ff       <= rcv_in;
         negs_ff      <= negs_in;
         samp_ff      <= samp_in;
         j_ff         <= j_in;
         r_ff         <= r_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sel_ff      <= sel_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      elem_ff     <= elem_in;
      tgt_ff      <= tgt_in;
      acc_ff      <= acc_in;
      step_ff     <= step_in;
      w_ff        <= w_in;
      old_ff      <= old_in;
      rc_ff       <= rc_in;
      lcg_ff      <= lcg_in;
      neg_ff      <= neg_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (word_we) begin
         word_mem[word_waddr] <= word_wdata;
      end
      word_rd_ff <= word_mem[word_raddr];
   end

   always_ff @(posedge clock) begin
      if (pmi_we) begin
         pmi_mem[ctx_waddr] <= ctx_wdata;
      end
      pmi_rd_ff <= pmi_mem[ctx_raddr];
   end

   always_ff @(posedge clock) begin
      if (esa_we) begin
         esa_mem[ctx_waddr] <= ctx_wdata;
      end
      esa_rd_ff <= esa_mem[ctx_raddr];
   end

   // entries not written since the train item started read as zero
   always_ff @(posedge clock) begin
      if (rc_we) begin
         rc_mem[j_ff] <= rc_wdata;
      end
      rc_rd_ff  <= rc_mem[j_ff];
      rcv_rd_ff <= rcv_ff[j_ff];
   end

   `SGDNS_ASSERT_HOLDS(a_div_start_idle, clock, reset, div_req.start, !div_rsp.busy)
   `SGDNS_ASSERT_HOLDS(a_samp_bound, clock, reset, state_ff != S_IDLE, samp_ff <= negs_ff)
   `SGDNS_ASSERT_HOLDS(a_one_table_writer, clock, reset, word_we, !(pmi_we || esa_we))
   `SGDNS_ASSERT_NEXT(a_done_loads_rsp, clock, reset, (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready), rsp_valid_ff)

endmodule

// ===== sim/tb_sgd_factorization_negative_sampling_core.sv =====
// testbench for the sgd factorization core: random training streams checked against a predictor
`timescale 1ns / 1ps
module tb_sgd_factorization_negative_sampling_core;
   import sgdns_pkg::*;

   localparam int QUIET_LIMIT = 3000000;
   localparam longint unsigned GEN_MUL = 64'd25214903917;
   localparam longint unsigned GEN_ADD = 64'd11;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   sgd_factorization_negative_sampling_core u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   // predictor state
   int word_tab[int];
   int pmi_tab[int];
   int esa_tab[int];
   logic [15:0] learn_rate = 16'd13107;
   logic [3:0] pmi_negs = 4'd4;
   logic [3:0] esa_negs = 4'd4;
   logic [12:0] pmi_cols = 13'd4096;
   logic [12:0] esa_cols = 13'd4096;
   logic [12:0] word_rows = 13'd4096;
   logic [7:0] vec_len = 8'd128;
   logic [15:0] step_rate = 16'd13107;
   logic [31:0] neg_seed = 32'd1;

   int read_data_q[$];
   int error_count = 0;
   bit steady = 1'b0;
   int hold_count = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int quiet = 0;

   function automatic int sat(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
   endfunction

   function automatic longint fl16(longint v);
      return v >>> 16;
   endfunction

   function automatic int eff_count(logic [12:0] v, int bound);
      if (v == 0) return 1;
      return (v > bound) ? bound : int'(v);
   endfunction

   function automatic int ctx_get(bit sel, int idx);
      if (sel) return esa_tab.exists(idx) ? esa_tab[idx] : 0;
      return pmi_tab.exists(idx) ? pmi_tab[idx] : 0;
   endfunction

   function automatic void ctx_put(bit sel, int idx, int v);
      if (sel) esa_tab[idx] = v;
      else pmi_tab[idx] = v;
   endfunction

   function automatic int word_get(int idx);
      return word_tab.exists(idx) ? word_tab[idx] : 0;
   endfunction

   // applies one accepted item to the predicted tables, returns the expected read_data
   function automatic int next_read_data(action_type act, bit sel, logic [11:0] row,
                                         logic [11:0] col, logic [6:0] elem, int tgt);
      int len;
      int rc[MAX_DIM];
      int negs, modulus, c, wbase, f, g, step, old;
      longint acc, tv;
      longint unsigned gen;
      len = (vec_len == 0) ? 1 : ((vec_len > MAX_DIM) ? MAX_DIM : int'(vec_len));
      wbase = int'(row) * MAX_DIM;
      case (act)
         ACT_TRAIN: begin
            negs = sel ? int'(esa_negs) : int'(pmi_negs);
            modulus = eff_count(sel ? esa_cols : pmi_cols, MAX_COLUMNS);
            c = int'(col);
            tv = longint'(tgt);
            for (int j = 0; j < MAX_DIM; j++) rc[j] = 0;
            for (int i = 0; i <= negs; i++) begin
               if (i != 0) begin
                  gen = longint'(neg_seed) * GEN_MUL + GEN_ADD;
                  neg_seed = 32'(gen % longint'(modulus));
                  c = int'(neg_seed);
                  tv = 0;
               end
               acc = 0;
               for (int j = 0; j < len; j++)
                  acc += fl16(longint'(word_get(wbase + j)) * longint'(ctx_get(sel, c * MAX_DIM + j)));
               f = sat(acc);
               g = sat(tv - longint'(f));
               step = sat(fl16(longint'({16'd0, step_rate}) * longint'(g)));
               for (int j = 0; j < len; j++) begin
                  old = ctx_get(sel, c * MAX_DIM + j);
                  rc[j] = sat(longint'(rc[j]) + longint'(sat(fl16(longint'(step) * longint'(old)))));
                  ctx_put(sel, c * MAX_DIM + j, sat(longint'(old) +
                     longint'(sat(fl16(longint'(step) * longint'(word_get(wbase + j)))))));
               end
            end
            for (int j = 0; j < len; j++)
               word_tab[wbase + j] = sat(longint'(word_get(wbase + j)) + longint'(rc[j]));
            return 0;
         end
         ACT_PASS: begin
            step_rate = 16'((32'(step_rate) * 32'd4) / 32'd5);
            return 0;
         end
         ACT_INIT: begin
            pmi_tab.delete();
            esa_tab.delete();
            gen = 64'd1;
            for (int r = 0; r < eff_count(word_rows, MAX_ROWS); r++)
               for (int j = 0; j < len; j++) begin
                  gen = gen * GEN_MUL + GEN_ADD;
                  acc = longint'(gen & 64'hFFFF) - 64'sd32768;
                  word_tab[r * MAX_DIM + j] = int'(acc / longint'(len));
               end
            neg_seed = 32'd1;
            step_rate = learn_rate;
            return 0;
         end
         default: return word_get(wbase + int'(elem));
      endcase
   endfunction

   task automatic flag_mismatch(string what, int got, int want);
      $display("mismatch %s: got %08h expected %08h", what, got, want);
      error_count++;
   endtask

   // sends one item and leaves req_tvalid as it is after acceptance
   task automatic send_entry(action_type act, bit sel, logic [11:0] row, logic [11:0] col,
                             logic [6:0] elem, int tgt);
      csr_valid <= 1'b0;
      if (!steady && $urandom_range(99) < 16) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while (!steady && $urandom_range(99) < 16) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= {sel, act};
      req_tdata <= {1'b0, tgt, elem, col, row};
      do @(posedge clock); while (!req_tready);
      read_data_q.push_back(next_read_data(act, sel, row, col, elem, tgt));
   endtask

   // register writes happen only once every expected result is back
   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [15:0] value);
      req_tvalid <= 1'b0;
      while (read_data_q.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_LEARNING_RATE: learn_rate = value;
         REG_PMI_NEGATIVES: pmi_negs = value[3:0];
         REG_ESA_NEGATIVES: esa_negs = value[3:0];
         REG_PMI_COLUMNS:   pmi_cols = value[12:0];
         REG_ESA_COLUMNS:   esa_cols = value[12:0];
         REG_WORD_ROWS:     word_rows = value[12:0];
         REG_VECTOR_LENGTH: vec_len = value[7:0];
         default: ;
      endcase
   endtask

   function automatic int pick_target();
      case ($urandom_range(4))
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         2: return int'($urandom);
         default: return int'($urandom_range(262143)) - 131072;
      endcase
   endfunction

   // random item over rows 0..rows-1, reads only touch elements already written
   task automatic random_entry(int rows);
      logic [11:0] row;
      logic [6:0] elem;
      int pick;
      pick = $urandom_range(99);
      row = 12'($urandom_range(rows - 1));
      if (pick < 60) begin
         send_entry(ACT_TRAIN, 1'($urandom), row, 12'($urandom), 7'($urandom), pick_target());
      end else if (pick < 90) begin
         do elem = 7'($urandom_range(($urandom_range(1) == 0) ? 127 : 7));
         while (!word_tab.exists(int'(row) * MAX_DIM + int'(elem)));
         send_entry(ACT_READ, 1'($urandom), row, 12'($urandom), elem, int'($urandom));
      end else begin
         send_entry(ACT_PASS, 1'($urandom), 12'($urandom), 12'($urandom), 7'($urandom),
                    int'($urandom));
      end
   endtask

   // long vectors from a single row, extreme register settings
   task automatic test_wide_vectors();
      write_reg(REG_LEARNING_RATE, 16'hFFFF);
      write_reg(REG_PMI_NEGATIVES, 16'd0);
      write_reg(REG_ESA_NEGATIVES, 16'd15);
      write_reg(REG_PMI_COLUMNS, 16'd0);
      write_reg(REG_ESA_COLUMNS, 16'd8191);
      write_reg(REG_WORD_ROWS, 16'd0);
      write_reg(REG_VECTOR_LENGTH, 16'd255);
      write_reg(3'd7, 16'hFFFF);
      send_entry(ACT_INIT, 1'b1, 12'hFFF, 12'hFFF, 7'h7F, -1);
      send_entry(ACT_READ, 1'b0, 12'd0, 12'd0, 7'd0, 0);
      send_entry(ACT_READ, 1'b1, 12'd0, 12'hFFF, 7'd127, -1);
      send_entry(ACT_TRAIN, 1'b0, 12'd0, 12'd0, 7'd0, 32'sh7FFFFFFF);
      send_entry(ACT_TRAIN, 1'b0, 12'd0, 12'hFFF, 7'd0, 32'sh80000000);
      send_entry(ACT_TRAIN, 1'b1, 12'd0, 12'd17, 7'd0, 32'sh00010000);
      send_entry(ACT_READ, 1'b0, 12'd0, 12'd0, 7'd5, 0);
      send_entry(ACT_PASS, 1'b0, 12'hFFF, 12'd0, 7'h7F, 0);
      send_entry(ACT_PASS, 1'b1, 12'd0, 12'hFFF, 7'd0, -1);
      send_entry(ACT_TRAIN, 1'b1, 12'd0, 12'hFFF, 7'd0, -65536);
      send_entry(ACT_READ, 1'b0, 12'd0, 12'd0, 7'd127, 0);
      send_entry(ACT_READ, 1'b0, 12'd0, 12'd0, 7'd64, 0);
   endtask

   // short vectors over several rows with normal idling
   task automatic test_short_vectors();
      write_reg(REG_LEARNING_RATE, 16'($urandom_range(1000, 40000)));
      write_reg(REG_WORD_ROWS, 16'd6);
      write_reg(REG_VECTOR_LENGTH, 16'd8);
      write_reg(REG_PMI_NEGATIVES, 16'd3);
      write_reg(REG_ESA_NEGATIVES, 16'd0);
      write_reg(REG_PMI_COLUMNS, 16'd4096);
      write_reg(REG_ESA_COLUMNS, 16'd1);
      send_entry(ACT_INIT, 1'b0, 12'd0, 12'd0, 7'd0, 0);
      repeat (100) random_entry(6);
   endtask

   // back to back traffic, no idling on either side
   task automatic test_steady_stream();
      write_reg(REG_VECTOR_LENGTH, 16'd0);
      write_reg(REG_PMI_NEGATIVES, 16'd15);
      write_reg(REG_PMI_COLUMNS, 16'd5);
      steady = 1'b1;
      repeat (100) random_entry(6);
      steady = 1'b0;
   endtask

   // receiver holds off while items keep coming
   task automatic test_backpressure();
      write_reg(REG_VECTOR_LENGTH, 16'd7);
      write_reg(REG_ESA_NEGATIVES, 16'd15);
      write_reg(REG_ESA_COLUMNS, 16'd4095);
      hold_count++;
      repeat (100) random_entry(6);
   endtask

   // registers that only matter at the next init, plus mixed counts
   task automatic test_register_mix();
      write_reg(REG_LEARNING_RATE, 16'd0);
      write_reg(REG_WORD_ROWS, 16'd8191);
      write_reg(REG_VECTOR_LENGTH, 16'd8);
      write_reg(REG_PMI_NEGATIVES, 16'($urandom_range(15)));
      write_reg(REG_ESA_NEGATIVES, 16'($urandom_range(15)));
      write_reg(REG_PMI_COLUMNS, 16'($urandom_range(1, 4096)));
      write_reg(REG_ESA_COLUMNS, 16'($urandom_range(1, 4096)));
      repeat (100) random_entry(6);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_wide_vectors();
      test_short_vectors();
      test_steady_stream();
      test_backpressure();
      test_register_mix();
      req_tvalid <= 1'b0;
      while (read_data_q.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // result side ready, with a long counted hold when asked; the hold outlasts two
   // of the longest train items so the core ends up waiting with a full output
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_seen != hold_count) begin
         hold_seen <= hold_count;
         hold_left <= 4000;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= 16);
      end
   end

   // check each result beat against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (read_data_q.size() == 0) begin
            flag_mismatch("unexpected beat", int'(rsp_tdata), 0);
         end else begin
            if (int'(rsp_tdata) != read_data_q[0])
               flag_mismatch("read_data", int'(rsp_tdata), read_data_q[0]);
            void'(read_data_q.pop_front());
         end
      end
   end

   // watchdog on cycles with no accepted beat on any channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

endmodule
